// ----- hdl/ipfd_pkg.sv -----
// Shared types and constants for the infrared pulse frame decoder.
package ipfd_pkg;

    localparam int DUR_W    = 16;
    localparam int CODE_W   = 20;
    localparam int CNT_W    = 5;
    localparam int TOL_W    = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CNT_W-1:0] MAX_BITS = CNT_W'(20);
    localparam logic [CNT_W-1:0] BITS_A   = CNT_W'(12);
    localparam logic [CNT_W-1:0] BITS_B   = CNT_W'(15);
    localparam logic [CNT_W-1:0] BITS_C   = CNT_W'(20);

    localparam logic [TOL_W-1:0] TOL_MAX       = TOL_W'(100);
    localparam logic [TOL_W-1:0] TOL_RESET     = TOL_W'(25);
    localparam logic [CNT_W-1:0] MATCH_BITS_RESET = CNT_W'(12);

    // Window scales: nominal lengths are 600 * k, so len*(100 -/+ t)/100 = 6*k*(100 -/+ t)
    localparam logic [DUR_W-1:0] SCALE_600  = DUR_W'(6);
    localparam logic [DUR_W-1:0] SCALE_1200 = DUR_W'(12);
    localparam logic [DUR_W-1:0] SCALE_2400 = DUR_W'(24);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOLERANCE  = 2'd0,
        CFG_MATCH_CODE = 2'd1,
        CFG_MATCH_BITS = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        PH_HDR_MARK,
        PH_HDR_SPACE,
        PH_BIT_MARK,
        PH_BIT_SPACE,
        PH_DONE_OK,
        PH_DONE_FAIL
    } t_phase;

    typedef struct packed {
        logic hdr_mark;   // within 2400 window
        logic short_len;  // within 600 window
        logic one_mark;   // within 1200 window
        logic long_len;   // at least the 600 lower bound
    } t_pulse_class;

endpackage

// ----- hdl/ipfd_window.sv -----
// Duration classification against the tolerance windows.
module ipfd_window (
    input  logic [ipfd_pkg::TOL_W-1:0] i_tol,
    input  logic [ipfd_pkg::DUR_W-1:0] i_duration_us,
    output ipfd_pkg::t_pulse_class     o_cls
);
    import ipfd_pkg::*;

    logic [TOL_W-1:0] tol_c;
    logic [DUR_W-1:0] minus_f;
    logic [DUR_W-1:0] plus_f;
    logic [DUR_W-1:0] lo_600, hi_600, lo_1200, hi_1200, lo_2400, hi_2400;

    always_comb begin
        tol_c   = (i_tol > TOL_MAX) ? TOL_MAX : i_tol;
        minus_f = DUR_W'(TOL_MAX) - DUR_W'(tol_c);
        plus_f  = DUR_W'(TOL_MAX) + DUR_W'(tol_c);
        lo_600  = minus_f * SCALE_600;
        hi_600  = plus_f  * SCALE_600;
        lo_1200 = minus_f * SCALE_1200;
        hi_1200 = plus_f  * SCALE_1200;
        lo_2400 = minus_f * SCALE_2400;
        hi_2400 = plus_f  * SCALE_2400;

        o_cls.hdr_mark  = (i_duration_us >= lo_2400) && (i_duration_us <= hi_2400);
        o_cls.one_mark  = (i_duration_us >= lo_1200) && (i_duration_us <= hi_1200);
        o_cls.short_len = (i_duration_us >= lo_600)  && (i_duration_us <= hi_600);
        o_cls.long_len  = (i_duration_us >= lo_600);
    end

endmodule

// ----- hdl/ipfd_frame.sv -----
// Frame state machine: phase, shifted code and bit count, plus the end-of-capture verdict.
module ipfd_frame (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic                        i_kind,
    input  logic                        i_level,
    input  ipfd_pkg::t_pulse_class      i_cls,
    input  logic [ipfd_pkg::CODE_W-1:0] i_match_code,
    input  logic [ipfd_pkg::CNT_W-1:0]  i_match_bits,
    output logic                        o_decoded,
    output logic [ipfd_pkg::CODE_W-1:0] o_code,
    output logic [ipfd_pkg::CNT_W-1:0]  o_bit_count,
    output logic                        o_is_match
);
    import ipfd_pkg::*;

    t_phase            r_phase, n_phase;
    logic [CODE_W-1:0] r_shift, n_shift;
    logic [CNT_W-1:0]  r_bits,  n_bits;
    logic [CNT_W-1:0]  bits_inc;
    logic              mark;
    logic              ok;

    assign mark     = i_level;
    assign bits_inc = r_bits + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR_MARK;
            r_shift <= '0;
            r_bits  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_shift <= n_shift;
            r_bits  <= n_bits;
        end
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_shift = r_shift;
        n_bits  = r_bits;
        if (i_kind) begin
            n_phase = PH_HDR_MARK;
            n_shift = '0;
            n_bits  = '0;
        end else begin
            unique case (r_phase)
                PH_HDR_MARK: begin
                    n_phase = (mark && i_cls.hdr_mark) ? PH_HDR_SPACE : PH_DONE_FAIL;
                end
                PH_HDR_SPACE: begin
                    if (!mark && i_cls.short_len) begin
                        n_phase = PH_BIT_MARK;
                        n_shift = '0;
                        n_bits  = '0;
                    end else begin
                        n_phase = PH_DONE_FAIL;
                    end
                end
                PH_BIT_MARK: begin
                    if (mark && (i_cls.one_mark || i_cls.short_len)) begin
                        // 1200 window wins where the two overlap
                        n_shift = {r_shift[CODE_W-2:0], i_cls.one_mark};
                        n_phase = PH_BIT_SPACE;
                    end else begin
                        n_phase = (r_bits == BITS_A || r_bits == BITS_B)
                                  ? PH_DONE_OK : PH_DONE_FAIL;
                    end
                end
                PH_BIT_SPACE: begin
                    if (!mark && i_cls.short_len) begin
                        n_bits  = bits_inc;
                        n_phase = (bits_inc >= MAX_BITS) ? PH_DONE_OK : PH_BIT_MARK;
                    end else if (!mark && i_cls.long_len) begin
                        n_bits  = bits_inc;
                        n_phase = (bits_inc == BITS_A || bits_inc == BITS_B ||
                                   bits_inc == BITS_C) ? PH_DONE_OK : PH_DONE_FAIL;
                    end else begin
                        n_phase = PH_DONE_FAIL;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // verdict for an end-of-capture transaction
    always_comb begin
        unique case (r_phase)
            PH_DONE_OK:  ok = 1'b1;
            PH_BIT_MARK: ok = (r_bits == BITS_A) || (r_bits == BITS_B);
            default:     ok = 1'b0;
        endcase
        o_decoded   = ok;
        o_code      = ok ? r_shift : '0;
        o_bit_count = ok ? r_bits  : '0;
        o_is_match  = ok && (r_shift == i_match_code) && (r_bits == i_match_bits);
    end

endmodule

// ----- hdl/ir_pulse_frame_decoder_top.sv -----
// Top level of the infrared pulse frame decoder: input and result registers, config.
// A pulse transaction is registered in the input register, then applied to the frame state;
// an end-of-capture result passes through the input register and then the result register.
// Throughput: one transaction per cycle, but an end-of-capture stalls while a result is held.
// Reset (synchronous, active low) clears the frame state and valid flags and restores
// tolerance 25, match code 0, match bits 12.
module ir_pulse_frame_decoder_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_kind,
    input  logic                            i_level,
    input  logic [ipfd_pkg::DUR_W-1:0]      i_duration_us,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_decoded,
    output logic [ipfd_pkg::CODE_W-1:0]     o_code,
    output logic [ipfd_pkg::CNT_W-1:0]      o_bit_count,
    output logic                            o_is_match,
    input  logic                            i_cfg_we,
    input  logic [ipfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ipfd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ipfd_pkg::*;

    logic [TOL_W-1:0]  r_tol;
    logic [CODE_W-1:0] r_match_code;
    logic [CNT_W-1:0]  r_match_bits;

    logic              r_in_valid;
    logic              r_kind;
    logic              r_level;
    logic [DUR_W-1:0]  r_dur;

    logic              r_out_valid;
    logic              r_decoded;
    logic [CODE_W-1:0] r_code;
    logic [CNT_W-1:0]  r_bit_count;
    logic              r_is_match;

    logic              advance;
    logic              in_accept;
    t_pulse_class      cls;
    logic              f_decoded;
    logic [CODE_W-1:0] f_code;
    logic [CNT_W-1:0]  f_bit_count;
    logic              f_is_match;

    // pulses never produce a result, so only end-of-capture waits on the output
    assign advance    = r_in_valid && (!r_kind || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol        <= TOL_RESET;
            r_match_code <= '0;
            r_match_bits <= MATCH_BITS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TOLERANCE:  r_tol        <= i_cfg_data[TOL_W-1:0];
                CFG_MATCH_CODE: r_match_code <= i_cfg_data[CODE_W-1:0];
                CFG_MATCH_BITS: r_match_bits <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_accept || (r_in_valid && !advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind  <= i_kind;
            r_level <= i_level;
            r_dur   <= i_duration_us;
        end
    end

    ipfd_window u_window (
        .i_tol         (r_tol),
        .i_duration_us (r_dur),
        .o_cls         (cls)
    );

    ipfd_frame u_frame (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_kind       (r_kind),
        .i_level      (r_level),
        .i_cls        (cls),
        .i_match_code (r_match_code),
        .i_match_bits (r_match_bits),
        .o_decoded    (f_decoded),
        .o_code       (f_code),
        .o_bit_count  (f_bit_count),
        .o_is_match   (f_is_match)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (advance && r_kind) || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_kind) begin
            r_decoded   <= f_decoded;
            r_code      <= f_code;
            r_bit_count <= f_bit_count;
            r_is_match  <= f_is_match;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_decoded   = r_decoded;
    assign o_code      = r_code;
    assign o_bit_count = r_bit_count;
    assign o_is_match  = r_is_match;

    // a held end-of-capture must not overwrite a result still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_kind && r_out_valid && i_out_stall) |=> r_in_valid && r_kind)
        else $error("end-of-capture advanced over a stalled result");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_decoded) |-> (o_code == '0 && o_bit_count == '0 && !o_is_match))
        else $error("failed frame carries nonzero payload");

    a_ok_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_decoded) |->
        (o_bit_count == BITS_A || o_bit_count == BITS_B || o_bit_count == BITS_C))
        else $error("decoded frame with illegal bit count");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(advance && r_kind))
        else $error("result without an end-of-capture transaction");

endmodule
